/* hdl/mbe_pkg.sv */
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int CFG_W       = 16;
  localparam int COUNT_W     = 16;
  localparam int OUT_W       = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_MAX_ITERATIONS = 1'b0;
  localparam logic REG_ESCAPE_LIMIT   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_LAUNCH,
    ST_WAIT,
    ST_DONE
  } core_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_iterations;
    logic [CFG_W-1:0] escape_limit;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

/* hdl/mbe_front.sv */
`timescale 1ns / 1ps

module mbe_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mbe_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_cx,
  input  logic signed [COORD_WIDTH-1:0] in_cy,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic signed [COORD_WIDTH-1:0] q_cx,
  output logic signed [COORD_WIDTH-1:0] q_cy,
  output logic                          q_skip
);

  localparam int PTR_W = (mbe_pkg::QUEUE_DEPTH > 1) ? $clog2(mbe_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mbe_pkg::QUEUE_DEPTH + 1);

  logic signed [COORD_WIDTH-1:0] cx_mem [mbe_pkg::QUEUE_DEPTH];
  logic signed [COORD_WIDTH-1:0] cy_mem [mbe_pkg::QUEUE_DEPTH];
  logic                          skip_mem [mbe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [CNT_W-1:0]              count;
  logic                          push;
  logic                          pop;
  logic                          skip_in;

  assign in_ready = (count != CNT_W'(mbe_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  // a point that can run no iteration goes straight to the result
  assign skip_in  = (cfg.max_iterations == '0) || (cfg.escape_limit == '0);

  assign q_cx   = cx_mem[rd_ptr];
  assign q_cy   = cy_mem[rd_ptr];
  assign q_skip = skip_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      cx_mem[wr_ptr]   <= in_cx;
      cy_mem[wr_ptr]   <= in_cy;
      skip_mem[wr_ptr] <= skip_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/mbe_mul.sv */
`timescale 1ns / 1ps

module mbe_mul #(
  parameter int MAG_W     = 45,
  parameter int FRAC_BITS = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] a,
  input  logic [MAG_W-1:0] b,
  output logic             done,
  output logic [MAG_W-1:0] res
);

  localparam int HALF   = (MAG_W + 1) / 2;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam logic [2:0] LAST_PP  = 3'd3;
  localparam logic [2:0] SAT_STEP = 3'd5;

  logic [MAG_W-1:0]  a_r;
  logic [MAG_W-1:0]  b_r;
  logic [2:0]        step;
  logic              busy;
  logic [2*HALF-1:0] pp;
  logic [1:0]        pp_sel;
  logic [PROD_W-1:0] acc;
  logic [HALF-1:0]   a_lo;
  logic [HALF-1:0]   a_hi;
  logic [HALF-1:0]   b_lo;
  logic [HALF-1:0]   b_hi;
  logic [HALF-1:0]   op_a;
  logic [HALF-1:0]   op_b;
  logic [PROD_W-1:0] pp_shifted;
  logic [SH_W-1:0]   shifted;
  logic [SH_W-1:0]   cap;

  assign a_lo = a_r[HALF-1:0];
  assign b_lo = b_r[HALF-1:0];
  assign a_hi = HALF'(a_r[MAG_W-1:HALF]);
  assign b_hi = HALF'(b_r[MAG_W-1:HALF]);

  always_comb begin
    case (step[1:0])
      2'd0:    begin op_a = a_lo; op_b = b_lo; end
      2'd1:    begin op_a = a_lo; op_b = b_hi; end
      2'd2:    begin op_a = a_hi; op_b = b_lo; end
      default: begin op_a = a_hi; op_b = b_hi; end
    endcase
  end

  always_comb begin
    case (pp_sel)
      2'd0:        pp_shifted = PROD_W'(pp);
      2'd1, 2'd2:  pp_shifted = PROD_W'(pp) << HALF;
      default:     pp_shifted = PROD_W'(pp) << (2 * HALF);
    endcase
  end

  assign shifted = acc[PROD_W-1:FRAC_BITS];
  assign cap     = SH_W'(1) << (16 + FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == SAT_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (busy) begin
      if (step <= LAST_PP) begin
        pp     <= op_a * op_b;
        pp_sel <= step[1:0];
      end
      if ((step != '0) && (step <= LAST_PP + 3'd1)) begin
        acc <= acc + pp_shifted;
      end
      if (step == SAT_STEP) begin
        res <= (shifted > cap) ? cap[MAG_W-1:0] : shifted[MAG_W-1:0];
      end
    end
  end

endmodule

/* hdl/mbe_core.sv */
`timescale 1ns / 1ps

module mbe_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mbe_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic signed [COORD_WIDTH-1:0] q_cx,
  input  logic signed [COORD_WIDTH-1:0] q_cy,
  input  logic                          q_skip,
  output mbe_pkg::result_t              res,
  input  logic                          res_ready
);

  localparam int Z_W    = 18 + FRAC_BITS;
  localparam int MAG_W  = 17 + FRAC_BITS;
  localparam int CMP_W  = MAG_W + 1;
  localparam int BASE_W = (MAG_W + 2 > COORD_WIDTH) ? MAG_W + 2 : COORD_WIDTH;
  localparam int S_W    = BASE_W + 2;

  mbe_pkg::core_state_t state;
  mbe_pkg::core_state_t state_next;

  logic signed [COORD_WIDTH-1:0]  cx;
  logic signed [COORD_WIDTH-1:0]  cy;
  logic signed [Z_W-1:0]          x;
  logic signed [Z_W-1:0]          y;
  logic [MAG_W-1:0]               x2;
  logic [MAG_W-1:0]               y2;
  logic [MAG_W-1:0]               xy;
  logic [mbe_pkg::COUNT_W-1:0]    iter;
  logic [MAG_W-1:0]               mag_x;
  logic [MAG_W-1:0]               mag_y;
  logic [CMP_W-1:0]               mag_sum;
  logic [CMP_W-1:0]               limit;
  logic                           keep_going;
  logic signed [S_W-1:0]          x2_s;
  logic signed [S_W-1:0]          y2_s;
  logic signed [S_W-1:0]          txy_s;
  logic signed [S_W-1:0]          cx_s;
  logic signed [S_W-1:0]          cy_s;
  logic signed [S_W-1:0]          zmax_s;
  logic signed [S_W-1:0]          nx_full;
  logic signed [S_W-1:0]          ny_full;
  logic signed [Z_W-1:0]          nx;
  logic signed [Z_W-1:0]          ny;
  logic                           mul_start;
  logic                           done_xx;
  logic                           done_yy;
  logic                           done_xy;
  logic [MAG_W-1:0]               res_xx;
  logic [MAG_W-1:0]               res_yy;
  logic [MAG_W-1:0]               res_xy;

  assign mag_x = x[Z_W-1] ? MAG_W'(-x) : MAG_W'(x);
  assign mag_y = y[Z_W-1] ? MAG_W'(-y) : MAG_W'(y);

  assign mag_sum    = CMP_W'(x2) + CMP_W'(y2);
  assign limit      = CMP_W'(cfg.escape_limit) << FRAC_BITS;
  assign keep_going = (iter < cfg.max_iterations) && (mag_sum < limit);

  assign x2_s   = S_W'($signed({1'b0, x2}));
  assign y2_s   = S_W'($signed({1'b0, y2}));
  assign txy_s  = S_W'($signed({1'b0, xy, 1'b0}));
  assign cx_s   = S_W'(cx);
  assign cy_s   = S_W'(cy);
  assign zmax_s = (S_W'(1) << (17 + FRAC_BITS)) - S_W'(1);

  assign nx_full = x2_s - y2_s + cx_s;
  assign ny_full = ((x[Z_W-1] ^ y[Z_W-1]) ? -txy_s : txy_s) + cy_s;

  always_comb begin
    if (nx_full > zmax_s) begin
      nx = Z_W'(zmax_s);
    end else if (nx_full < -zmax_s) begin
      nx = Z_W'(-zmax_s);
    end else begin
      nx = Z_W'(nx_full);
    end
    if (ny_full > zmax_s) begin
      ny = Z_W'(zmax_s);
    end else if (ny_full < -zmax_s) begin
      ny = Z_W'(-zmax_s);
    end else begin
      ny = Z_W'(ny_full);
    end
  end

  mbe_mul #(.MAG_W(MAG_W), .FRAC_BITS(FRAC_BITS)) u_mul_xx (
    .clk(clk), .rst(rst), .start(mul_start), .a(mag_x), .b(mag_x),
    .done(done_xx), .res(res_xx)
  );

  mbe_mul #(.MAG_W(MAG_W), .FRAC_BITS(FRAC_BITS)) u_mul_yy (
    .clk(clk), .rst(rst), .start(mul_start), .a(mag_y), .b(mag_y),
    .done(done_yy), .res(res_yy)
  );

  mbe_mul #(.MAG_W(MAG_W), .FRAC_BITS(FRAC_BITS)) u_mul_xy (
    .clk(clk), .rst(rst), .start(mul_start), .a(mag_x), .b(mag_y),
    .done(done_xy), .res(res_xy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_start  = 1'b0;
    res.valid  = 1'b0;
    res.count  = iter;
    unique case (state)
      mbe_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_skip ? mbe_pkg::ST_DONE : mbe_pkg::ST_CHECK;
        end
      end
      mbe_pkg::ST_CHECK: begin
        state_next = keep_going ? mbe_pkg::ST_UPDATE : mbe_pkg::ST_DONE;
      end
      mbe_pkg::ST_UPDATE: begin
        state_next = mbe_pkg::ST_LAUNCH;
      end
      mbe_pkg::ST_LAUNCH: begin
        mul_start  = 1'b1;
        state_next = mbe_pkg::ST_WAIT;
      end
      mbe_pkg::ST_WAIT: begin
        if (done_xx && done_yy && done_xy) begin
          state_next = mbe_pkg::ST_CHECK;
        end
      end
      mbe_pkg::ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = mbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      mbe_pkg::ST_IDLE: begin
        if (q_valid) begin
          cx   <= q_cx;
          cy   <= q_cy;
          x    <= '0;
          y    <= '0;
          x2   <= '0;
          y2   <= '0;
          xy   <= '0;
          iter <= '0;
        end
      end
      mbe_pkg::ST_UPDATE: begin
        x    <= nx;
        y    <= ny;
        iter <= iter + 1'b1;
      end
      mbe_pkg::ST_WAIT: begin
        if (done_xx && done_yy && done_xy) begin
          x2 <= res_xx;
          y2 <= res_yy;
          xy <= res_xy;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/mandelbrot_escape_iteration.sv */
`timescale 1ns / 1ps
// Each iteration waits on the multipliers, which build each product from four partial products.
// The core works on one point at a time; a two-entry queue takes requests meanwhile.
// Reset (synchronous, rst high): queue and output empty, max_iterations = 175,
// escape_limit = 10000.

module mandelbrot_escape_iteration #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // c_real [COORD_WIDTH-1:0], c_imag [2*COORD_WIDTH-1:COORD_WIDTH], zero fill above
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // iteration_count [15:0], pixel_white [16], zero fill above
  output logic [mbe_pkg::OUT_W-1:0]        m_axis_tdata
);

  mbe_pkg::cfg_t    cfg;
  mbe_pkg::result_t res;
  logic                                res_ready;
  logic                                q_valid;
  logic                                q_pop;
  logic signed [COORD_WIDTH-1:0]       q_cx;
  logic signed [COORD_WIDTH-1:0]       q_cy;
  logic                                q_skip;
  logic                                out_valid;
  logic [mbe_pkg::COUNT_W-1:0]         out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iterations <= mbe_pkg::CFG_W'(175);
      cfg.escape_limit   <= mbe_pkg::CFG_W'(10000);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbe_pkg::REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data;
        mbe_pkg::REG_ESCAPE_LIMIT:   cfg.escape_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mbe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cx    ($signed(s_axis_tdata[COORD_WIDTH-1:0])),
    .in_cy    ($signed(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cx     (q_cx),
    .q_cy     (q_cy),
    .q_skip   (q_skip)
  );

  mbe_core #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cx      (q_cx),
    .q_cy      (q_cy),
    .q_skip    (q_skip),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_count <= res.count;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(mbe_pkg::OUT_W - mbe_pkg::COUNT_W - 1){1'b0}},
                          out_count[0], out_count};

endmodule
